>>> design/rfs_pkg.sv
// Shared constants, types and pointer helper for the ring FIFO with search.
package rfs_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int WORD_W = 64;
  localparam int OP_W   = 2;
  localparam int CAP_W  = 7;
  localparam int OCC_W  = 7;
  localparam int ST_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_HAS = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              found;
    logic [OCC_W-1:0]  occupancy;
    logic [ST_W-1:0]   status;
  } rfs_res_t;

  // next slot, wrapping at the effective capacity
  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

>>> design/rfs_mem.sv
// Entry store: one write port, one read port with registered read data.
module rfs_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rfs_pkg::PTR_W-1:0] waddr,
  input  logic [rfs_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [rfs_pkg::PTR_W-1:0] raddr,
  output logic [rfs_pkg::WORD_W-1:0] rdata
);
  import rfs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rfs_engine.sv
// Sequencer: pointers, count, capacity and the single compare used by search.
module rfs_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [rfs_pkg::OP_W-1:0]   opcode,
  input  logic [rfs_pkg::WORD_W-1:0] value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rfs_pkg::CAP_W-1:0]  cfg_data,
  output rfs_pkg::rfs_res_t          res,
  output logic                       res_valid,
  input  logic                       res_take,
  output logic                       mem_we,
  output logic [rfs_pkg::PTR_W-1:0]  mem_waddr,
  output logic [rfs_pkg::WORD_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [rfs_pkg::PTR_W-1:0]  mem_raddr,
  input  logic [rfs_pkg::WORD_W-1:0] mem_rdata
);
  import rfs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DEQ  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] val;
  logic [CAP_W-1:0]  capacity;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  scan;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  cap_eff;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  assign mem_we    = (state == S_EXEC) && (op == OP_ENQ) && (count < cap_eff);
  assign mem_waddr = wptr;
  assign mem_wdata = val;
  assign mem_re    = ((state == S_EXEC) && ((op == OP_DEQ) || (op == OP_HAS)))
                   || (state == S_SRCH);
  assign mem_raddr = (state == S_SRCH) ? scan : rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAP_RESET;
      rptr     <= '0;
      wptr     <= '0;
      count    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid && (count == '0)) begin
            capacity <= cfg_data;
            rptr     <= '0;
            wptr     <= '0;
          end
          if (req_valid) begin
            op    <= opcode;
            val   <= value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res.read_value <= '0;
          res.found      <= 1'b0;
          res.status     <= ST_OK;
          res.occupancy  <= OCC_W'(count);
          state          <= S_FIN;
          case (op)
            OP_ENQ: begin
              if (count >= cap_eff) begin
                res.status <= ST_FULL;
              end else begin
                wptr          <= adv(wptr, cap_eff);
                count         <= count + CNT_W'(1);
                res.occupancy <= OCC_W'(count + CNT_W'(1));
              end
            end
            OP_DEQ: begin
              if (count == '0) begin
                res.status <= ST_EMPTY;
              end else begin
                rptr          <= adv(rptr, cap_eff);
                count         <= count - CNT_W'(1);
                res.occupancy <= OCC_W'(count - CNT_W'(1));
                state         <= S_DEQ;
              end
            end
            OP_HAS: begin
              if (count != '0) begin
                scan  <= adv(rptr, cap_eff);
                k     <= '0;
                state <= S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
        S_DEQ: begin
          res.read_value <= mem_rdata;
          state          <= S_FIN;
        end
        S_SRCH: begin
          // read data belongs to the slot issued last cycle
          if (mem_rdata == val) begin
            res.found <= 1'b1;
            state     <= S_FIN;
          end else if (k == count - CNT_W'(1)) begin
            state <= S_FIN;
          end else begin
            k    <= k + CNT_W'(1);
            scan <= adv(scan, cap_eff);
          end
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/ring_fifo_with_search.sv
// Top level of the ring FIFO with membership search: engine, store, output register.
//
// Request channel (req_valid / req_stall, opcode, value): one item per operation,
//   taken when req_valid is high and req_stall low. Opcodes: enqueue, dequeue,
//   contains search; the unused code is a no-op that reports occupancy.
// Response channel (rsp_valid / rsp_stall): one item per request, in order,
//   carrying read_value, found, occupancy (after the op) and status.
// Config channel (cfg_valid / cfg_ready, cfg_data): writes capacity. Taken only
//   while no request is in flight; ignored unless the queue is empty, and then
//   both pointers go back to slot 0. Capacity 0 acts as 1, above 64 as 64.
// Path, accept to rsp_valid: EXEC, then FIN, then the output register; a non-empty
//   dequeue adds DEQ, a non-empty search adds SRCH from the oldest entry to a hit
//   or the last occupied one. The next request is taken in the cycle after the
//   result moves on. The search walks the store through its single registered
//   read port, one entry a cycle, one 64-bit compare.
// The output register parts the two sides: the next request is taken while a
//   response waits under rsp_stall, but that request's own result is held in
//   the engine until the register frees up.
// Reset (rst, synchronous): empty queue, pointers 0, capacity 64, no response
//   pending. Store contents are not cleared; only data of written slots is ever used.
module ring_fifo_with_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [rfs_pkg::OP_W-1:0]   opcode,
  input  logic [rfs_pkg::WORD_W-1:0] value,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [rfs_pkg::WORD_W-1:0] read_value,
  output logic                       found,
  output logic [rfs_pkg::OCC_W-1:0]  occupancy,
  output logic [rfs_pkg::ST_W-1:0]   status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rfs_pkg::CAP_W-1:0]  cfg_data
);
  import rfs_pkg::*;

  rfs_res_t          res;
  logic              res_valid;
  logic              res_take;
  logic              out_free;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // output register is free when empty or being drained this cycle
  assign out_free = !rsp_valid || !rsp_stall;
  assign res_take = res_valid && out_free;

  rfs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (opcode),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rfs_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= res_valid;
    end
  end

  // payload only moves when a new result lands, so it holds under stall
  always_ff @(posedge clk) begin
    if (res_take) begin
      read_value <= res.read_value;
      found      <= res.found;
      occupancy  <= res.occupancy;
      status     <= res.status;
    end
  end

endmodule
